/* rtl/adaptive_step_detector_core_defines.svh */
// Assertion macros for the adaptive step detector.
// Used by modules that check their own control sequencing; needs clk and rst in scope.
`ifndef ADAPTIVE_STEP_DETECTOR_CORE_DEFINES_SVH
`define ADAPTIVE_STEP_DETECTOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/asd_pkg.sv */
// Shared types and constants of the adaptive step detector.
// No dependencies; imported by the interfaces, the datapath, the controller and the top level.
`default_nettype none

package asd_pkg;

  localparam int THR_W      = 17;
  localparam int GAIN_W     = 16;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [THR_W-1:0] THR_MAX = 17'h1FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINIMUM_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DECAY        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_MARGIN       = 3'd5;

  localparam logic [GAIN_W-1:0] DEF_LOWPASS_GAIN      = 16'd5243;
  localparam logic [THR_W-1:0]  DEF_MINIMUM_THRESHOLD = 17'd225;
  localparam logic [GAIN_W-1:0] DEF_DEVIATION_SCALE   = 16'd20480;
  localparam logic [GAIN_W-1:0] DEF_REFRACTORY_TIME   = 16'd260;
  localparam logic [GAIN_W-1:0] DEF_PEAK_DECAY        = 16'd62915;
  localparam logic [GAIN_W-1:0] DEF_PEAK_MARGIN       = 16'd17695;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ,
    S_MAG_GO,
    S_MAG_WAIT,
    S_LP_MUL,
    S_LP_ADD,
    S_HP,
    S_SQR,
    S_WIN,
    S_STAT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SIG_GO,
    S_SIG_WAIT,
    S_THR_MUL,
    S_CLAMP,
    S_MARGIN,
    S_DECIDE
  } asd_state_t;

  typedef struct packed {
    logic load_in;
    logic load_sq;
    logic mag_go;
    logic load_mag;
    logic load_lp_prod;
    logic load_lp;
    logic load_hp;
    logic load_sqr;
    logic load_win;
    logic load_stat;
    logic div_go;
    logic sig_go;
    logic load_sigma;
    logic load_thr_prod;
    logic load_thr;
    logic load_margin;
    logic commit;
  } asd_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic short_window;
  } asd_status_t;

endpackage

`default_nettype wire

/* rtl/asd_if.sv */
// Channel interfaces of the adaptive step detector: sample, result and configuration.
// Depends on asd_pkg for field widths.
`default_nettype none

interface asd_sample_if #(parameter int SAMPLE_WIDTH = 16);
  import asd_pkg::*;
  logic                           valid;
  logic                           ready;
  logic        [TIME_W-1:0]       time_ms;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;
  modport source(output valid, time_ms, accel_x, accel_y, accel_z, input ready);
  modport sink(input valid, time_ms, accel_x, accel_y, accel_z, output ready);
endinterface

interface asd_result_if;
  import asd_pkg::*;
  logic               valid;
  logic               ready;
  logic               step_found;
  logic [THR_W-1:0]   current_threshold;
  logic [COUNT_W-1:0] step_total;
  modport source(output valid, step_found, current_threshold, step_total, input ready);
  modport sink(input valid, step_found, current_threshold, step_total, output ready);
endinterface

interface asd_cfg_if;
  import asd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/asd_isqrt.sv */
// Iterative floor integer square root, one root bit per cycle.
// Depends on nothing; shared by the magnitude and deviation steps.
`default_nettype none

module asd_isqrt #(
  parameter int ROOT_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [2*ROOT_WIDTH-1:0] operand,
  output logic                         done,
  output logic      [ROOT_WIDTH-1:0]   root
);

  localparam int CNTW = $clog2(ROOT_WIDTH);

  logic                    busy;
  logic [CNTW-1:0]         cnt;
  logic [2*ROOT_WIDTH-1:0] opnd;
  logic [ROOT_WIDTH:0]     rem;
  logic [ROOT_WIDTH+2:0]   rem_sh;
  logic [ROOT_WIDTH+2:0]   trial;
  logic [ROOT_WIDTH+2:0]   rem_sub;
  logic                    take;

  always_comb begin
    rem_sh  = {rem, opnd[2*ROOT_WIDTH-1:2*ROOT_WIDTH-2]};
    trial   = {1'b0, root, 2'b01};
    take    = rem_sh >= trial;
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(ROOT_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd <= operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      opnd <= {opnd[2*ROOT_WIDTH-3:0], 2'b00};
      rem  <= take ? rem_sub[ROOT_WIDTH:0] : rem_sh[ROOT_WIDTH:0];
      root <= {root[ROOT_WIDTH-2:0], take};
    end
  end

endmodule

`default_nettype wire

/* rtl/asd_divider.sv */
// Restoring divider, one quotient bit per cycle, for a quotient known to fit QUO_WIDTH bits.
// Depends on nothing; used for the variance of the window.
`default_nettype none

module asd_divider #(
  parameter int DEN_WIDTH = 12,
  parameter int QUO_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [DEN_WIDTH+QUO_WIDTH-1:0] dividend,
  input  wire logic [DEN_WIDTH-1:0]           divisor,
  output logic                                done,
  output logic      [QUO_WIDTH-1:0]           quotient
);

  localparam int CNTW = $clog2(QUO_WIDTH);

  logic                 busy;
  logic [CNTW-1:0]      cnt;
  logic [DEN_WIDTH-1:0] rem;
  logic [DEN_WIDTH-1:0] den;
  logic [QUO_WIDTH-1:0] low;
  logic [DEN_WIDTH:0]   sh;
  logic [DEN_WIDTH:0]   sub;
  logic                 take;

  always_comb begin
    sh   = {rem, low[QUO_WIDTH-1]};
    take = sh >= {1'b0, den};
    sub  = sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(QUO_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[DEN_WIDTH+QUO_WIDTH-1:QUO_WIDTH];
      low      <= dividend[QUO_WIDTH-1:0];
      den      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= take ? sub[DEN_WIDTH-1:0] : sh[DEN_WIDTH-1:0];
      low      <= {low[QUO_WIDTH-2:0], 1'b0};
      quotient <= {quotient[QUO_WIDTH-2:0], take};
    end
  end

endmodule

`default_nettype wire

/* rtl/asd_datapath.sv */
// Datapath of the step detector: filter, window memory, statistics, threshold and decision.
// Depends on asd_pkg, asd_isqrt and asd_divider; driven by asd_ctrl commands.
`default_nettype none

module asd_datapath #(
  parameter int WINDOW_DEPTH = 40,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire asd_pkg::asd_cmd_t                 cmd,
  output asd_pkg::asd_status_t                   status,
  input  wire logic        [asd_pkg::TIME_W-1:0] time_ms,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    accel_x,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    accel_y,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    accel_z,
  input  wire logic                              cfg_valid,
  input  wire logic [asd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [asd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                   step_found,
  output logic      [asd_pkg::THR_W-1:0]         current_threshold,
  output logic      [asd_pkg::COUNT_W-1:0]       step_total
);

  import asd_pkg::*;

  localparam int MW   = SAMPLE_WIDTH;
  localparam int SQW  = 2 * MW;
  localparam int LPW  = MW + 16;
  localparam int HPW  = MW + 1;
  localparam int PW   = $clog2(WINDOW_DEPTH);
  localparam int NW   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUMW = MW + NW + 1;
  localparam int SSW  = 2 * MW + NW;
  localparam int CW   = 2 * (MW + NW);
  localparam int QW   = 2 * MW;
  localparam int DENW = 2 * NW;
  localparam int PRW  = LPW + 1 + GAIN_W;
  localparam int TW   = (MW + 2 > THR_W) ? MW + 2 : THR_W;
  localparam int PKW  = (MW + 14 > THR_W + 16) ? MW + 14 : THR_W + 16;
  localparam int XW   = (HPW > THR_W) ? HPW + 1 : THR_W + 1;

  logic [GAIN_W-1:0] gain_q;
  logic [THR_W-1:0]  min_thr_q;
  logic [GAIN_W-1:0] scale_q;
  logic [GAIN_W-1:0] refr_q;
  logic [GAIN_W-1:0] decay_q;
  logic [GAIN_W-1:0] margin_q;

  logic [TIME_W-1:0]      t_q;
  logic [MW-1:0]          ax_q, ay_q, az_q;
  logic [SQW-1:0]         sumsq_q;
  logic [MW-1:0]          mag_q;
  logic [LPW-1:0]         lp_q;
  logic [PRW-1:0]         lp_prod_q;
  logic                   lp_neg_q;
  logic signed [HPW-1:0]  hp_q;
  logic signed [HPW-1:0]  old_q;
  logic signed [HPW-1:0]  prev_q;
  logic [SQW-1:0]         hsq_q, osq_q;
  logic [MW-1:0]          peak_q, peak_dec_q;
  logic [PW-1:0]          wpos_q;
  logic [NW-1:0]          fill_q;
  logic signed [SUMW-1:0] sum_q;
  logic [SSW-1:0]         sqsum_q;
  logic [CW-1:0]          a_q, b_q;
  logic [DENW-1:0]        n2_q;
  logic [MW-1:0]          sigma_q;
  logic [MW+1:0]          tprod_q;
  logic [THR_W-1:0]       thr_q;
  logic [THR_W+15:0]      mprod_q;
  logic [TIME_W-1:0]      last_q;
  logic [COUNT_W-1:0]     count_q;

  logic signed [HPW-1:0] win_mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] win_vld;
  logic signed [HPW-1:0] rd_q;
  logic                  rd_vld_q;

  logic [MW-1:0]          ax, ay, az;
  logic [SQW-1:0]         sq_x, sq_y, sq_z;
  logic signed [LPW:0]    diff;
  logic [LPW:0]           diff_abs;
  logic [PRW:0]           lp_rnd;
  logic [LPW+1:0]         lp_inc;
  logic [LPW+1:0]         lp_sum;
  logic [MW-1:0]          hp_abs, old_abs;
  logic [MW+15:0]         pd_full;
  logic [MW+NW-1:0]       s1;
  logic [CW-1:0]          dividend;
  logic [MW+15:0]         tp_full;
  logic [TW-1:0]          t_ext, tsel;
  logic                   pk_ok, crossed, refr_ok, step;
  logic signed [XW-1:0]   thr_s, hp_s, prev_s;
  logic [TIME_W-1:0]      elapsed;
  logic [SQW-1:0]         root_in;
  logic                   sqrt_done, div_done;
  logic [MW-1:0]          root;
  logic [QW-1:0]          quotient;

  always_comb begin
    ax   = accel_x[MW-1] ? MW'(-accel_x) : MW'(accel_x);
    ay   = accel_y[MW-1] ? MW'(-accel_y) : MW'(accel_y);
    az   = accel_z[MW-1] ? MW'(-accel_z) : MW'(accel_z);
    sq_x = SQW'(ax_q) * SQW'(ax_q);
    sq_y = SQW'(ay_q) * SQW'(ay_q);
    sq_z = SQW'(az_q) * SQW'(az_q);

    diff     = $signed({1'b0, mag_q, 16'b0}) - $signed({1'b0, lp_q});
    diff_abs = diff[LPW] ? (LPW+1)'(-diff) : (LPW+1)'(diff);
    lp_rnd   = {1'b0, lp_prod_q} + (lp_neg_q ? (PRW+1)'(16'hFFFF) : '0);
    lp_inc   = lp_rnd[PRW:16];
    lp_sum   = lp_neg_q ? {2'b00, lp_q} - lp_inc : {2'b00, lp_q} + lp_inc;

    hp_abs  = hp_q[HPW-1] ? MW'(-hp_q) : MW'(hp_q);
    old_abs = old_q[HPW-1] ? MW'(-old_q) : MW'(old_q);
    pd_full = (MW+16)'(peak_q) * (MW+16)'(decay_q);

    s1       = sum_q[SUMW-1] ? (MW+NW)'(-sum_q) : (MW+NW)'(sum_q);
    dividend = (a_q > b_q) ? a_q - b_q : '0;
    root_in  = cmd.sig_go ? quotient : sumsq_q;

    tp_full = (MW+16)'(sigma_q) * (MW+16)'(scale_q);
    t_ext   = TW'(tprod_q);
    tsel    = (t_ext < TW'(min_thr_q)) ? TW'(min_thr_q) : t_ext;

    pk_ok   = PKW'({peak_q, 14'b0}) > PKW'(mprod_q);
    thr_s   = XW'($signed({1'b0, thr_q}));
    hp_s    = XW'(hp_q);
    prev_s  = XW'(prev_q);
    crossed = (prev_s < thr_s) && (hp_s >= thr_s);
    elapsed = t_q - last_q;
    refr_ok = elapsed >= TIME_W'(refr_q);
    step    = crossed && refr_ok && pk_ok;

    status.sqrt_done    = sqrt_done;
    status.div_done     = div_done;
    status.short_window = fill_q < NW'(2);
  end

  asd_isqrt #(.ROOT_WIDTH(MW)) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mag_go | cmd.sig_go),
    .operand (root_in),
    .done    (sqrt_done),
    .root    (root)
  );

  asd_divider #(.DEN_WIDTH(DENW), .QUO_WIDTH(QW)) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (dividend),
    .divisor  (n2_q),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q    <= DEF_LOWPASS_GAIN;
      min_thr_q <= DEF_MINIMUM_THRESHOLD;
      scale_q   <= DEF_DEVIATION_SCALE;
      refr_q    <= DEF_REFRACTORY_TIME;
      decay_q   <= DEF_PEAK_DECAY;
      margin_q  <= DEF_PEAK_MARGIN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOWPASS_GAIN:      gain_q    <= cfg_data[GAIN_W-1:0];
        CFG_MINIMUM_THRESHOLD: min_thr_q <= cfg_data[THR_W-1:0];
        CFG_DEVIATION_SCALE:   scale_q   <= cfg_data[GAIN_W-1:0];
        CFG_REFRACTORY_TIME:   refr_q    <= cfg_data[GAIN_W-1:0];
        CFG_PEAK_DECAY:        decay_q   <= cfg_data[GAIN_W-1:0];
        CFG_PEAK_MARGIN:       margin_q  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rd_q <= win_mem[wpos_q];
    end
    if (cmd.load_win) begin
      win_mem[wpos_q] <= hp_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lp_q     <= '0;
      prev_q   <= '0;
      peak_q   <= '0;
      win_vld  <= '0;
      rd_vld_q <= 1'b0;
      wpos_q   <= '0;
      fill_q   <= '0;
      sum_q    <= '0;
      sqsum_q  <= '0;
      last_q   <= '0;
      count_q  <= '0;
    end else begin
      if (cmd.load_in) begin
        rd_vld_q <= win_vld[wpos_q];
      end
      if (cmd.load_lp) begin
        lp_q <= lp_sum[LPW-1:0];
      end
      if (cmd.load_win) begin
        win_vld[wpos_q] <= 1'b1;
        wpos_q  <= (wpos_q == PW'(WINDOW_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
        if (fill_q < NW'(WINDOW_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
        sum_q   <= sum_q + SUMW'(hp_q) - SUMW'(old_q);
        sqsum_q <= sqsum_q + SSW'(hsq_q) - SSW'(osq_q);
        peak_q  <= ($signed({1'b0, peak_dec_q}) < hp_q) ? hp_q[MW-1:0] : peak_dec_q;
      end
      if (cmd.commit) begin
        prev_q <= hp_q;
        if (step) begin
          count_q <= count_q + 1'b1;
          last_q  <= t_q;
          peak_q  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      t_q  <= time_ms;
      ax_q <= ax;
      ay_q <= ay;
      az_q <= az;
    end
    if (cmd.load_sq) begin
      sumsq_q <= sq_x + sq_y + sq_z;
    end
    if (cmd.load_mag) begin
      mag_q <= root;
    end
    if (cmd.load_lp_prod) begin
      lp_prod_q <= PRW'(diff_abs) * PRW'(gain_q);
      lp_neg_q  <= diff[LPW];
    end
    if (cmd.load_hp) begin
      hp_q  <= $signed({1'b0, mag_q}) - $signed({1'b0, lp_q[LPW-1:16]});
      old_q <= rd_vld_q ? rd_q : '0;
    end
    if (cmd.load_sqr) begin
      hsq_q      <= SQW'(hp_abs) * SQW'(hp_abs);
      osq_q      <= SQW'(old_abs) * SQW'(old_abs);
      peak_dec_q <= pd_full[MW+15:16];
    end
    if (cmd.load_stat) begin
      a_q  <= CW'(fill_q) * CW'(sqsum_q);
      b_q  <= CW'(s1) * CW'(s1);
      n2_q <= DENW'(fill_q) * DENW'(fill_q);
      if (status.short_window) begin
        sigma_q <= '0;
      end
    end
    if (cmd.load_sigma) begin
      sigma_q <= root;
    end
    if (cmd.load_thr_prod) begin
      tprod_q <= tp_full[MW+15:14];
    end
    if (cmd.load_thr) begin
      thr_q <= (tsel > TW'(THR_MAX)) ? THR_MAX : tsel[THR_W-1:0];
    end
    if (cmd.load_margin) begin
      mprod_q <= (THR_W+16)'(thr_q) * (THR_W+16)'(margin_q);
    end
    if (cmd.commit) begin
      step_found        <= step;
      current_threshold <= thr_q;
      step_total        <= step ? count_q + 1'b1 : count_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/asd_ctrl.sv */
// Sequencing state machine of the step detector and the result handshake.
// Depends on asd_pkg and the assertion macros header.
`default_nettype none

`include "adaptive_step_detector_core_defines.svh"

module asd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire asd_pkg::asd_status_t status,
  output asd_pkg::asd_cmd_t         cmd
);

  import asd_pkg::*;

  asd_state_t state, state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_SQ;
      S_SQ:       state_next = S_MAG_GO;
      S_MAG_GO:   state_next = S_MAG_WAIT;
      S_MAG_WAIT: if (status.sqrt_done) state_next = S_LP_MUL;
      S_LP_MUL:   state_next = S_LP_ADD;
      S_LP_ADD:   state_next = S_HP;
      S_HP:       state_next = S_SQR;
      S_SQR:      state_next = S_WIN;
      S_WIN:      state_next = S_STAT;
      S_STAT:     state_next = status.short_window ? S_THR_MUL : S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: if (status.div_done) state_next = S_SIG_GO;
      S_SIG_GO:   state_next = S_SIG_WAIT;
      S_SIG_WAIT: if (status.sqrt_done) state_next = S_THR_MUL;
      S_THR_MUL:  state_next = S_CLAMP;
      S_CLAMP:    state_next = S_MARGIN;
      S_MARGIN:   state_next = S_DECIDE;
      S_DECIDE:   if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_SQ:       cmd.load_sq = 1'b1;
      S_MAG_GO:   cmd.mag_go = 1'b1;
      S_MAG_WAIT: cmd.load_mag = status.sqrt_done;
      S_LP_MUL:   cmd.load_lp_prod = 1'b1;
      S_LP_ADD:   cmd.load_lp = 1'b1;
      S_HP:       cmd.load_hp = 1'b1;
      S_SQR:      cmd.load_sqr = 1'b1;
      S_WIN:      cmd.load_win = 1'b1;
      S_STAT:     cmd.load_stat = 1'b1;
      S_DIV_GO:   cmd.div_go = 1'b1;
      S_DIV_WAIT: ;
      S_SIG_GO:   cmd.sig_go = 1'b1;
      S_SIG_WAIT: cmd.load_sigma = status.sqrt_done;
      S_THR_MUL:  cmd.load_thr_prod = 1'b1;
      S_CLAMP:    cmd.load_thr = 1'b1;
      S_MARGIN:   cmd.load_margin = 1'b1;
      S_DECIDE:   cmd.commit = out_free;
      default: ;
    endcase
  end

  `ASD_ASSERT_NOW(a_commit_free, cmd.commit, !out_valid || out_ready, "result overwritten before it was taken")
  `ASD_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == S_SQ, "accepted request not started")
  `ASD_ASSERT_NOW(a_result_from_commit, $rose(out_valid), $past(cmd.commit), "result raised without a commit")
  `ASD_ASSERT_NOW(a_sqrt_expected, status.sqrt_done, state == S_MAG_WAIT || state == S_SIG_WAIT, "square root finished while not awaited")
  `ASD_ASSERT_NOW(a_div_expected, status.div_done, state == S_DIV_WAIT, "division finished while not awaited")

endmodule

`default_nettype wire

/* rtl/adaptive_step_detector_core.sv */
// Top level of the adaptive step detector: joins the controller and the datapath to the channels.
// Depends on asd_pkg, asd_if, asd_ctrl and asd_datapath.
`default_nettype none

// Each accepted request is one timestamped three-axis sample and yields exactly one result
// carrying the step flag, the threshold used and the running step count. The time a sample
// takes is set by the shared bit-serial square root, used twice, and the bit-serial variance
// divider; while the window holds fewer than two entries the division and second root are skipped.
// The next request is taken once the previous result has been placed in the output register, and
// a result is held there until the sink takes it. Configuration writes are always accepted and
// should be made only while no request is in flight; unknown indexes are ignored.
module adaptive_step_detector_core #(
  parameter int WINDOW_DEPTH = 40,
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  asd_sample_if.sink sample,
  asd_result_if.source result,
  asd_cfg_if.sink    cfg
);

  import asd_pkg::*;

  asd_cmd_t    cmd;
  asd_status_t status;

  assign cfg.ready = 1'b1;

  asd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  asd_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .time_ms           (sample.time_ms),
    .accel_x           (sample.accel_x),
    .accel_y           (sample.accel_y),
    .accel_z           (sample.accel_z),
    .cfg_valid         (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .step_found        (result.step_found),
    .current_threshold (result.current_threshold),
    .step_total        (result.step_total)
  );

endmodule

`default_nettype wire
